[rtl/core/fpr_pkg.sv]
// fpr_pkg: shared types and constants for the fifo page replacement block
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package fpr_pkg;

  // width of the frame count register and its value after reset
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 7'd4;

  // running counters
  localparam int TOTAL_W = 32;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // access type mark that makes a frame dirty ('W')
  localparam logic [7:0] WRITE_MARK = 8'h57;
  localparam logic WRITE_SETS_DIRTY = (WRITE_MARK == 8'h57);

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } fpr_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // accept an access, register tag matches, read victim page
    logic update;     // apply hit or replacement, load the result register
    logic cfg_write;  // load frame count and empty the frame table
  } fpr_cmd_t;

endpackage

[rtl/core/fpr_ram.sv]
// fpr_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fpr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

[rtl/core/fpr_ctrl.sv]
// fpr_ctrl: two-state sequencer for lookup and update, result and config handshakes
// depends on fpr_pkg
`timescale 1ns / 1ps

module fpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output fpr_pkg::fpr_cmd_t cmd
);

  fpr_pkg::fpr_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  // result register can take a new transaction
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpr_pkg::ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          state_nxt = fpr_pkg::ST_UPDATE;
        end
      end
      fpr_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = fpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpr_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;
    cmd           = '0;
    case (state_r)
      fpr_pkg::ST_IDLE: begin
        in_stall      = cfg_valid;
        cfg_ready     = 1'b1;
        cmd.capture   = in_valid && !cfg_valid;
        cmd.cfg_write = cfg_valid;
      end
      fpr_pkg::ST_UPDATE: begin
        cmd.update = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/fpr_datapath.sv]
// fpr_datapath: frame tags, dirty bits, fifo pointer, counters and result register
// depends on fpr_pkg and fpr_ram
`timescale 1ns / 1ps

module fpr_datapath #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_BITS  = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fpr_pkg::fpr_cmd_t           cmd,
  input  logic [PAGE_BITS-1:0]        in_page_number,
  input  logic                        in_is_write,
  input  logic [fpr_pkg::CFG_W-1:0]   cfg_data,
  output logic                        out_hit,
  output logic                        out_writeback,
  output logic                        out_evicted_valid,
  output logic [PAGE_BITS-1:0]        out_evicted_page,
  output logic [fpr_pkg::TOTAL_W-1:0] out_event_total,
  output logic [fpr_pkg::TOTAL_W-1:0] out_read_total,
  output logic [fpr_pkg::TOTAL_W-1:0] out_write_total,
  output logic [fpr_pkg::TOTAL_W-1:0] out_fault_total
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (CNT_W > fpr_pkg::CFG_W) ? CNT_W : fpr_pkg::CFG_W;
  localparam int TW    = fpr_pkg::TOTAL_W;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v, input logic en);
    return (en && (v != fpr_pkg::COUNT_MAX)) ? v + TW'(1) : v;
  endfunction

  // configuration and table state
  logic [fpr_pkg::CFG_W-1:0] cfg_r;
  logic [CNT_W-1:0]          filled_r, filled_nxt;
  logic [IDX_W-1:0]          oldest_r, oldest_nxt;
  logic [MAX_FRAMES-1:0]     dirty_r, dirty_nxt;
  logic [PAGE_BITS-1:0]      tag_r [MAX_FRAMES];

  // captured transaction
  logic [PAGE_BITS-1:0]      page_r;
  logic                      wr_r;
  logic [MAX_FRAMES-1:0]     match_r, match_nxt;
  logic [PAGE_BITS-1:0]      victim_page;

  // counters
  logic [TW-1:0] event_r, read_r, write_r, fault_r;
  logic [TW-1:0] event_nxt, read_nxt, write_nxt, fault_nxt;

  // result register
  logic                 hit_r, wb_r, ev_valid_r;
  logic [PAGE_BITS-1:0] ev_page_r;

  logic [CMP_W-1:0] cfg_ext, n_full;
  logic [CNT_W-1:0] n_frames;
  logic [IDX_W-1:0] victim, slot;
  logic [CNT_W-1:0] oldest_inc;
  logic             hit, miss, free, evict, wb, dirty_in;

  // clamp frame count to one..MAX_FRAMES
  always_comb begin
    cfg_ext = CMP_W'(cfg_r);
    if (cfg_r == '0) begin
      n_full = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
      n_full = CMP_W'(MAX_FRAMES);
    end else begin
      n_full = cfg_ext;
    end
  end
  assign n_frames = n_full[CNT_W-1:0];

  // victim slot from the fifo pointer
  assign victim = (CNT_W'(oldest_r) >= n_frames) ? '0 : oldest_r;

  // parallel tag compare over filled frames
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match_nxt[i] = (tag_r[i] == in_page_number) && (CNT_W'(i) < filled_r);
    end
  end

  // victim page copy, read on capture
  fpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (cmd.update && miss),
    .wr_addr (slot),
    .wr_data (page_r),
    .rd_en   (cmd.capture),
    .rd_addr (victim),
    .rd_data (victim_page)
  );

  // hit or replacement decision
  assign hit        = |match_r;
  assign miss       = !hit;
  assign free       = filled_r < n_frames;
  assign slot       = free ? filled_r[IDX_W-1:0] : victim;
  assign evict      = miss && !free;
  assign wb         = evict && dirty_r[victim];
  assign dirty_in   = wr_r && fpr_pkg::WRITE_SETS_DIRTY;
  assign oldest_inc = CNT_W'(victim) + CNT_W'(1);

  // table state next values
  always_comb begin
    filled_nxt = filled_r;
    oldest_nxt = oldest_r;
    dirty_nxt  = dirty_r;
    if (cmd.cfg_write) begin
      filled_nxt = '0;
      oldest_nxt = '0;
      dirty_nxt  = '0;
    end else if (cmd.update) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (match_r[i] && dirty_in) begin
          dirty_nxt[i] = 1'b1;
        end
      end
      if (miss) begin
        dirty_nxt[slot] = dirty_in;
        if (free) begin
          filled_nxt = filled_r + CNT_W'(1);
        end else begin
          oldest_nxt = (oldest_inc >= n_frames) ? '0 : oldest_inc[IDX_W-1:0];
        end
      end
    end
  end

  // counter next values
  always_comb begin
    event_nxt = event_r;
    read_nxt  = read_r;
    write_nxt = write_r;
    fault_nxt = fault_r;
    if (cmd.update) begin
      event_nxt = sat_inc(event_r, 1'b1);
      read_nxt  = sat_inc(read_r, miss);
      write_nxt = sat_inc(write_r, wb);
      fault_nxt = sat_inc(fault_r, miss);
    end
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= fpr_pkg::FRAME_COUNT_RESET;
      filled_r <= '0;
      oldest_r <= '0;
      dirty_r  <= '0;
      event_r  <= '0;
      read_r   <= '0;
      write_r  <= '0;
      fault_r  <= '0;
    end else begin
      if (cmd.cfg_write) begin
        cfg_r <= cfg_data;
      end
      filled_r <= filled_nxt;
      oldest_r <= oldest_nxt;
      dirty_r  <= dirty_nxt;
      event_r  <= event_nxt;
      read_r   <= read_nxt;
      write_r  <= write_nxt;
      fault_r  <= fault_nxt;
    end
  end

  // frame tags, written on a fault
  always_ff @(posedge clk) begin
    if (cmd.update && miss) begin
      tag_r[slot] <= page_r;
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r  <= in_page_number;
      wr_r    <= in_is_write;
      match_r <= match_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_r      <= hit;
      wb_r       <= wb;
      ev_valid_r <= evict;
      ev_page_r  <= evict ? victim_page : '0;
    end
  end

  assign out_hit           = hit_r;
  assign out_writeback     = wb_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_event_total   = event_r;
  assign out_read_total    = read_r;
  assign out_write_total   = write_r;
  assign out_fault_total   = fault_r;

endmodule

[rtl/core/fifo_page_replacement.sv]
// fifo_page_replacement: fifo page replacement with a dirty bit per frame
// an accepted access is registered with its tag-match vector over all frames and its
//   victim page; the hit or replacement update then loads the result register, and
//   waits while the previous result is still stalled at the output; no new access is
//   taken until that update is done
// reset: synchronous, clears the frame table, dirty bits and counters, frame count 4
// depends on fpr_pkg, fpr_ctrl, fpr_datapath, fpr_ram
`timescale 1ns / 1ps

module fifo_page_replacement #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_BITS  = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PAGE_BITS-1:0]        in_page_number,
  input  logic                        in_is_write,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fpr_pkg::CFG_W-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic                        out_writeback,
  output logic                        out_evicted_valid,
  output logic [PAGE_BITS-1:0]        out_evicted_page,
  output logic [fpr_pkg::TOTAL_W-1:0] out_event_total,
  output logic [fpr_pkg::TOTAL_W-1:0] out_read_total,
  output logic [fpr_pkg::TOTAL_W-1:0] out_write_total,
  output logic [fpr_pkg::TOTAL_W-1:0] out_fault_total
);

  fpr_pkg::fpr_cmd_t cmd;

  // sequencer
  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // frame table and counters
  fpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page_number    (in_page_number),
    .in_is_write       (in_is_write),
    .cfg_data          (cfg_data),
    .out_hit           (out_hit),
    .out_writeback     (out_writeback),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_event_total   (out_event_total),
    .out_read_total    (out_read_total),
    .out_write_total   (out_write_total),
    .out_fault_total   (out_fault_total)
  );

  // no second access is taken while one is in the update state
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("access accepted during update");

  // a config write and an access never complete together
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !(in_valid && !in_stall))
    else $error("config write collided with an access");

  // a hit never evicts
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_evicted_valid && !out_writeback))
    else $error("hit reported an eviction");

  // a writeback only comes with an eviction
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback) |-> out_evicted_valid)
    else $error("writeback without eviction");

endmodule

[dv/fifo_page_replacement_tb.sv]
// fifo_page_replacement_tb: self-checking testbench for the fifo page replacement block
// a directed table, then random trace phases under several frame counts, checked against
// an in-bench predictor; depends on fpr_pkg and fifo_page_replacement
`timescale 1ns / 1ps

module fifo_page_replacement_tb;

  localparam int PAGE_W        = 20;
  localparam int FRAMES_MAX    = 64;
  localparam int PHASE_ITEMS   = 128;
  localparam int PHASE_COUNT   = 9;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ROW_COUNT     = 23;
  localparam int EXP_DEPTH     = 16;

  // one result transaction, in port order
  typedef struct packed {
    logic                        hit;
    logic                        writeback;
    logic                        evicted_valid;
    logic [PAGE_W-1:0]           evicted_page;
    logic [fpr_pkg::TOTAL_W-1:0] event_total;
    logic [fpr_pkg::TOTAL_W-1:0] read_total;
    logic [fpr_pkg::TOTAL_W-1:0] write_total;
    logic [fpr_pkg::TOTAL_W-1:0] fault_total;
  } page_result_t;

  typedef enum bit {
    ROW_ACCESS,
    ROW_CONFIG
  } row_kind_t;

  // directed row: an access (value is the page) or a frame count write (value[6:0])
  typedef struct {
    row_kind_t         kind;
    logic [PAGE_W-1:0] value;
    logic              wr;
    bit                typed;
    page_result_t      want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [PAGE_W-1:0]           in_page_number = '0;
  logic                        in_is_write = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [fpr_pkg::CFG_W-1:0]   cfg_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_hit;
  logic                        out_writeback;
  logic                        out_evicted_valid;
  logic [PAGE_W-1:0]           out_evicted_page;
  logic [fpr_pkg::TOTAL_W-1:0] out_event_total;
  logic [fpr_pkg::TOTAL_W-1:0] out_read_total;
  logic [fpr_pkg::TOTAL_W-1:0] out_write_total;
  logic [fpr_pkg::TOTAL_W-1:0] out_fault_total;

  // predictor state: frame table, fifo pointer, counters, frame count
  logic [PAGE_W-1:0]           frame_page [FRAMES_MAX];
  logic                        frame_dirty [FRAMES_MAX];
  int unsigned                 frames_filled = 0;
  int unsigned                 oldest_frame = 0;
  logic [fpr_pkg::CFG_W-1:0]   frame_count_reg = fpr_pkg::FRAME_COUNT_RESET;
  logic [fpr_pkg::TOTAL_W-1:0] event_cnt = '0;
  logic [fpr_pkg::TOTAL_W-1:0] read_cnt = '0;
  logic [fpr_pkg::TOTAL_W-1:0] write_cnt = '0;
  logic [fpr_pkg::TOTAL_W-1:0] fault_cnt = '0;

  // expected results in flight, a ring indexed by running write and read counts
  page_result_t expected_results [EXP_DEPTH];
  int           exp_wr_count = 0;
  int           exp_rd_count = 0;
  stim_row_t    directed_rows [ROW_COUNT];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  fifo_page_replacement i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .in_is_write       (in_is_write),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_writeback     (out_writeback),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_event_total   (out_event_total),
    .out_read_total    (out_read_total),
    .out_write_total   (out_write_total),
    .out_fault_total   (out_fault_total)
  );

  always #5 clk = ~clk;

  function automatic logic [fpr_pkg::TOTAL_W-1:0] sat_inc(
      input logic [fpr_pkg::TOTAL_W-1:0] v);
    return (v == fpr_pkg::COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // frame count as the block uses it: 0 acts as 1, above the table size acts as the size
  function automatic int unsigned frames_in_use(input logic [fpr_pkg::CFG_W-1:0] fc);
    if (fc == 0) return 1;
    if (fc > FRAMES_MAX) return FRAMES_MAX;
    return fc;
  endfunction

  // fifo replacement step: look up, mark dirty, fill or evict, bump the counters
  function automatic page_result_t predict_access(input logic [PAGE_W-1:0] page,
                                                  input logic wr);
    page_result_t r;
    int unsigned  n;
    int unsigned  v;
    bit           found;
    r = '0;
    found = 1'b0;
    n = frames_in_use(frame_count_reg);
    for (int i = 0; i < frames_filled; i++) begin
      if (frame_page[i] == page) begin
        found = 1'b1;
        if (wr) frame_dirty[i] = 1'b1;
      end
    end
    event_cnt = sat_inc(event_cnt);
    if (!found) begin
      read_cnt = sat_inc(read_cnt);
      fault_cnt = sat_inc(fault_cnt);
      if (frames_filled < n) begin
        frame_page[frames_filled] = page;
        frame_dirty[frames_filled] = wr;
        frames_filled = frames_filled + 1;
      end else begin
        v = (oldest_frame >= n) ? 0 : oldest_frame;
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[v];
        if (frame_dirty[v]) begin
          r.writeback = 1'b1;
          write_cnt = sat_inc(write_cnt);
        end
        frame_page[v] = page;
        frame_dirty[v] = wr;
        v = v + 1;
        oldest_frame = (v >= n) ? 0 : v;
      end
    end
    r.hit = found;
    r.event_total = event_cnt;
    r.read_total = read_cnt;
    r.write_total = write_cnt;
    r.fault_total = fault_cnt;
    return r;
  endfunction

  // send one access transaction, record its expectation, then maybe idle
  task automatic drive_access(input logic [PAGE_W-1:0] page, input logic wr,
                              input bit typed, input page_result_t want);
    page_result_t predicted;
    in_valid <= 1'b1;
    in_page_number <= page;
    in_is_write <= wr;
    do @(posedge clk); while (in_stall);
    predicted = predict_access(page, wr);
    expected_results[exp_wr_count % EXP_DEPTH] = typed ? want : predicted;
    exp_wr_count++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // hold the sender until every expected result is back and the block has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_wr_count != exp_rd_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frame count write while idle; the write also empties the frame table
  task automatic write_frame_count(input logic [fpr_pkg::CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_count_reg = value;
    frames_filled = 0;
    oldest_frame = 0;
    for (int i = 0; i < FRAMES_MAX; i++) frame_dirty[i] = 1'b0;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    page_result_t got;
    page_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hit, out_writeback, out_evicted_valid, out_evicted_page,
             out_event_total, out_read_total, out_write_total, out_fault_total};
      if (exp_rd_count == exp_wr_count) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = expected_results[exp_rd_count % EXP_DEPTH];
        exp_rd_count++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp hit=%0b wb=%0b ev=%0b pg=%h tot=%0d/%0d/%0d/%0d",
                     want.hit, want.writeback, want.evicted_valid, want.evicted_page,
                     want.event_total, want.read_total, want.write_total, want.fault_total);
            $display("          got hit=%0b wb=%0b ev=%0b pg=%h tot=%0d/%0d/%0d/%0d",
                     got.hit, got.writeback, got.evicted_valid, got.evicted_page,
                     got.event_total, got.read_total, got.write_total, got.fault_total);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [fpr_pkg::CFG_W-1:0] phase_cfg [PHASE_COUNT];
    logic [PAGE_W-1:0]         pool_base;
    logic [PAGE_W-1:0]         page;
    int unsigned               pool_size;
    stim_row_t                 row;

    for (int i = 0; i < FRAMES_MAX; i++) begin
      frame_page[i] = '0;
      frame_dirty[i] = 1'b0;
    end

    // reset frame count is 4; totals are event/read/write/fault
    directed_rows = '{
      '{ROW_ACCESS, 20'h00000, 1'b0, 1'b1, {3'b000, 20'h0, 32'd1, 32'd1, 32'd0, 32'd1}},
      '{ROW_ACCESS, 20'hFFFFF, 1'b1, 1'b1, {3'b000, 20'h0, 32'd2, 32'd2, 32'd0, 32'd2}},
      '{ROW_ACCESS, 20'h00000, 1'b1, 1'b1, {3'b100, 20'h0, 32'd3, 32'd2, 32'd0, 32'd2}},
      '{ROW_ACCESS, 20'h12345, 1'b0, 1'b1, {3'b000, 20'h0, 32'd4, 32'd3, 32'd0, 32'd3}},
      '{ROW_ACCESS, 20'h54321, 1'b1, 1'b1, {3'b000, 20'h0, 32'd5, 32'd4, 32'd0, 32'd4}},
      // table full: oldest page 0 was written, so it goes back to disk
      '{ROW_ACCESS, 20'hABCDE, 1'b0, 1'b1, {3'b011, 20'h0, 32'd6, 32'd5, 32'd1, 32'd5}},
      '{ROW_ACCESS, 20'hFFFFF, 1'b0, 1'b1, {3'b100, 20'h0, 32'd7, 32'd5, 32'd1, 32'd5}},
      '{ROW_ACCESS, 20'h00001, 1'b0, 1'b1, {3'b011, 20'hFFFFF, 32'd8, 32'd6, 32'd2, 32'd6}},
      // frame count 0 acts as a single frame; table emptied, counters kept
      '{ROW_CONFIG, 20'd0, 1'b0, 1'b0, '0},
      '{ROW_ACCESS, 20'h00005, 1'b1, 1'b1, {3'b000, 20'h0, 32'd9, 32'd7, 32'd2, 32'd7}},
      '{ROW_ACCESS, 20'h00005, 1'b0, 1'b1, {3'b100, 20'h0, 32'd10, 32'd7, 32'd2, 32'd7}},
      '{ROW_ACCESS, 20'h00006, 1'b0, 1'b1, {3'b011, 20'h5, 32'd11, 32'd8, 32'd3, 32'd8}},
      '{ROW_ACCESS, 20'h00007, 1'b1, 1'b1, {3'b001, 20'h6, 32'd12, 32'd9, 32'd3, 32'd9}},
      '{ROW_ACCESS, 20'h00007, 1'b0, 1'b1, {3'b100, 20'h0, 32'd13, 32'd9, 32'd3, 32'd9}},
      // frame count above the table size is clamped
      '{ROW_CONFIG, 20'd127, 1'b0, 1'b0, '0},
      '{ROW_ACCESS, 20'h00007, 1'b0, 1'b0, '0},
      '{ROW_ACCESS, 20'hFFFFF, 1'b1, 1'b0, '0},
      '{ROW_ACCESS, 20'h00000, 1'b0, 1'b0, '0},
      '{ROW_CONFIG, 20'd2, 1'b0, 1'b0, '0},
      '{ROW_ACCESS, 20'h00001, 1'b1, 1'b0, '0},
      '{ROW_ACCESS, 20'h00002, 1'b0, 1'b0, '0},
      '{ROW_ACCESS, 20'h00003, 1'b0, 1'b0, '0},
      '{ROW_ACCESS, 20'h00001, 1'b0, 1'b0, '0}
    };

    phase_cfg = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd8, 7'd65, 7'd3, 7'd4, 7'd16};
    phase_cfg[PHASE_COUNT-1] = fpr_pkg::CFG_W'($urandom_range(1, FRAMES_MAX));

    send_idle_pct = 9;
    recv_idle_pct = 56;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < ROW_COUNT; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CONFIG) write_frame_count(row.value[fpr_pkg::CFG_W-1:0]);
      else drive_access(row.value, row.wr, row.typed, row.want);
    end

    // random phases: pages mostly from a pool a bit larger than the table, some anywhere
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_frame_count(phase_cfg[p]);
      pool_base = PAGE_W'($urandom);
      pool_size = frames_in_use(phase_cfg[p]);
      pool_size = pool_size + pool_size / 2 + 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(99) < 85) page = pool_base + PAGE_W'($urandom_range(pool_size - 1));
        else page = PAGE_W'($urandom);
        drive_access(page, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    drain_results();
    if (exp_wr_count != exp_rd_count) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[fifo_page_replacement.f]
rtl/core/fpr_pkg.sv
rtl/core/fpr_ram.sv
rtl/core/fpr_ctrl.sv
rtl/core/fpr_datapath.sv
rtl/core/fifo_page_replacement.sv
dv/fifo_page_replacement_tb.sv
